@@ src/slb_pkg.sv @@
// Shared constants, types and command/status structs for the segment layout builder.
package slb_pkg;

  localparam int SIZE_W = 11;
  localparam int ADDR_W = 12;
  localparam int LEN_W = 7;
  localparam int SLOT_W = 3;
  localparam int CNT_W = 5;

  localparam int USER_BLOCK_CLICKS = 16;
  localparam int NUM_SLOTS = 8;

  localparam logic [ADDR_W-1:0] LIMIT_RESET = 12'd2048;
  localparam logic [LEN_W-1:0] LEN_FULL = 7'd127;
  localparam logic [SIZE_W-1:0] SEG_ROUND = 11'd127;
  localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd7;

  typedef struct packed {
    logic load;
    logic check;
    logic emit_err;
    logic emit_slot;
  } slb_cmd_t;

  typedef struct packed {
    logic err;
    logic last_slot;
    logic out_free;
  } slb_status_t;

endpackage

@@ src/slb_ctrl.sv @@
// Controller state machine: request capture, size check and result sequencing.
module slb_ctrl
  import slb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  slb_status_t status,
  output slb_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          if (status.err) begin
            cmd.emit_err = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.emit_slot = 1'b1;
            if (status.last_slot) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/slb_datapath.sv @@
// Datapath: request registers, limit register, size check and slot descriptor output register.
module slb_datapath
  import slb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  slb_cmd_t            cmd,
  output slb_status_t         status,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic [SIZE_W-1:0]   text_clicks,
  input  logic [SIZE_W-1:0]   data_clicks,
  input  logic [SIZE_W-1:0]   stack_clicks,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   slot,
  output logic [ADDR_W-1:0]   base_address,
  output logic [LEN_W-1:0]    length_field,
  output logic                writable,
  output logic                expand_down,
  output logic                in_use,
  output logic                error,
  output logic                last
);

  logic [ADDR_W-1:0] mem_limit;
  logic [SIZE_W-1:0] t_r;
  logic [SIZE_W-1:0] d_r;
  logic [SIZE_W-1:0] s_r;
  logic [CNT_W-1:0]  nt;
  logic [CNT_W-1:0]  nd;
  logic [CNT_W-1:0]  ns;
  logic [ADDR_W-1:0] stack_top;
  logic              err;
  logic [SLOT_W-1:0] slot_cnt;

  logic [SIZE_W:0]   t_round;
  logic [SIZE_W:0]   d_round;
  logic [SIZE_W:0]   s_round;
  logic [CNT_W:0]    cnt_sum;
  logic [ADDR_W:0]   total;
  logic              err_next;

  logic [CNT_W-1:0]  ie;
  logic [CNT_W:0]    nt_nd;
  logic              in_text;
  logic              in_data;
  logic              in_stack;
  logic [CNT_W-1:0]  j5;
  logic [SLOT_W-1:0] j;
  logic [SLOT_W-1:0] m;
  logic [SLOT_W:0]   m1;
  logic              text_full;
  logic              data_full;
  logic              stack_full;
  logic [ADDR_W-1:0] seg_base;
  logic [LEN_W-1:0]  seg_len;
  logic              seg_wr;
  logic              seg_ed;
  logic              seg_used;

  assign t_round = {1'b0, t_r} + {1'b0, SEG_ROUND};
  assign d_round = {1'b0, d_r} + {1'b0, SEG_ROUND};
  assign s_round = {1'b0, s_r} + {1'b0, SEG_ROUND};
  assign cnt_sum = {1'b0, t_round[SIZE_W:7]} + {1'b0, d_round[SIZE_W:7]}
                 + {1'b0, s_round[SIZE_W:7]};
  assign total = {2'b0, t_r} + {2'b0, d_r} + {2'b0, s_r}
               + (ADDR_W+1)'(USER_BLOCK_CLICKS);
  assign err_next = (cnt_sum > (CNT_W+1)'(NUM_SLOTS)) || (total > {1'b0, mem_limit});

  assign ie = {2'b0, slot_cnt};
  assign nt_nd = {1'b0, nt} + {1'b0, nd};
  assign in_text = ie < nt;
  assign in_data = {1'b0, ie} < nt_nd;
  assign in_stack = ({1'b0, ie} + {1'b0, ns}) >= (CNT_W+1)'(NUM_SLOTS);
  assign j5 = ie - nt;
  assign j = j5[SLOT_W-1:0];
  assign m = SLOT_LAST - slot_cnt;
  assign m1 = {1'b0, m} + 4'd1;
  assign text_full = {1'b0, slot_cnt} < t_r[SIZE_W-1:7];
  assign data_full = {1'b0, j} < d_r[SIZE_W-1:7];
  assign stack_full = {1'b0, m} < s_r[SIZE_W-1:7];

  always_comb begin
    seg_base = '0;
    seg_len = '0;
    seg_wr = 1'b0;
    seg_ed = 1'b0;
    seg_used = 1'b0;
    priority if (in_stack) begin
      seg_base = stack_top - {1'b0, m1, 7'b0};
      seg_len = stack_full ? LEN_FULL : (7'd0 - s_r[6:0]);
      seg_wr = 1'b1;
      seg_ed = !stack_full;
      seg_used = 1'b1;
    end else if (in_text) begin
      seg_base = {2'b0, slot_cnt, 7'b0};
      seg_len = text_full ? LEN_FULL : (t_r[6:0] - 7'd1);
      seg_used = 1'b1;
    end else if (in_data) begin
      seg_base = ADDR_W'(USER_BLOCK_CLICKS) + {2'b0, j, 7'b0};
      seg_len = data_full ? LEN_FULL : (d_r[6:0] - 7'd1);
      seg_wr = 1'b1;
      seg_used = 1'b1;
    end else begin
      seg_used = 1'b0;
    end
  end

  assign status.err = err;
  assign status.last_slot = (slot_cnt == SLOT_LAST);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      mem_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= text_clicks;
      d_r <= data_clicks;
      s_r <= stack_clicks;
      slot_cnt <= '0;
    end else if (cmd.emit_slot) begin
      slot_cnt <= slot_cnt + 3'd1;
    end
    if (cmd.check) begin
      nt <= t_round[SIZE_W:7];
      nd <= d_round[SIZE_W:7];
      ns <= s_round[SIZE_W:7];
      stack_top <= ADDR_W'(USER_BLOCK_CLICKS) + {1'b0, d_r} + {1'b0, s_r};
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_err || cmd.emit_slot) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      slot <= '0;
      base_address <= '0;
      length_field <= '0;
      writable <= 1'b0;
      expand_down <= 1'b0;
      in_use <= 1'b0;
      error <= 1'b1;
      last <= 1'b1;
    end else if (cmd.emit_slot) begin
      slot <= slot_cnt;
      base_address <= seg_base;
      length_field <= seg_len;
      writable <= seg_wr;
      expand_down <= seg_ed;
      in_use <= seg_used;
      error <= 1'b0;
      last <= (slot_cnt == SLOT_LAST);
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && !in_use)
    else $error("error result without last");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_slot |=> out_valid && !error)
    else $error("emitted slot not presented");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error && !in_use |-> base_address == '0 && length_field == '0)
    else $error("cleared slot carries data");

  a_ed_writable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error && expand_down |-> writable && in_use)
    else $error("expand-down segment not writable");

endmodule

@@ src/segment_layout_builder_unit.sv @@
// Segment layout builder top level: joins the controller and the datapath.
//
// Usage:
//   A request carries text_clicks, data_clicks and stack_clicks and is taken when
//   in_valid is high and in_stall is low. in_stall is high while a request is being
//   worked on, so one request is handled at a time.
//   Each good request yields eight results, slots 0 to 7 in order, the last one
//   with last set. A request that needs more than eight segments or exceeds
//   mem_limit yields one result with error and last set.
//   Results leave the output register at one result per cycle while out_stall is low.
//   Each request passes through capture and size check, then eight slots, or for a
//   refused request one error result.
//   While out_stall is high the output register holds its result and the
//   sequencer waits; the next request may be taken while the last result waits.
//   cfg_we writes cfg_data into mem_limit; write it only while the block is idle.
//   Reset (rst, synchronous) empties the output register, returns the controller
//   to idle and sets mem_limit to 2048.
module segment_layout_builder_unit
  import slb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SIZE_W-1:0]   text_clicks,
  input  logic [SIZE_W-1:0]   data_clicks,
  input  logic [SIZE_W-1:0]   stack_clicks,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   slot,
  output logic [ADDR_W-1:0]   base_address,
  output logic [LEN_W-1:0]    length_field,
  output logic                writable,
  output logic                expand_down,
  output logic                in_use,
  output logic                error,
  output logic                last
);

  slb_cmd_t    cmd;
  slb_status_t status;

  slb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  slb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .text_clicks  (text_clicks),
    .data_clicks  (data_clicks),
    .stack_clicks (stack_clicks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot         (slot),
    .base_address (base_address),
    .length_field (length_field),
    .writable     (writable),
    .expand_down  (expand_down),
    .in_use       (in_use),
    .error        (error),
    .last         (last)
  );

endmodule
